// File: sv/slm_pkg.sv
// Shared types, codes and constants for the spin lattice Metropolis update block.
`default_nettype none
package slm_pkg;

  localparam int SIDE_DEFAULT = 4;

  localparam int THR_W     = 14;
  localparam int FUNC_W    = 2;
  localparam int COORD_W   = 2;
  localparam int FIELD_W   = 4;
  localparam int ENERGY_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 3;

  localparam logic [THR_W-1:0] THR_FOUR_RESET   = 14'd183;
  localparam logic [THR_W-1:0] THR_EIGHT_RESET  = 14'd3;
  localparam logic [THR_W-1:0] THR_TWELVE_RESET = 14'd0;

  localparam logic [FUNC_W-1:0] FUNC_WRITE_SPIN     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_COUPLING = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE         = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_AT_FOUR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_AT_EIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_AT_TWELVE = 2'd2;

  localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
  localparam logic [STEP_W-1:0] STEP_XM     = 3'd1;
  localparam logic [STEP_W-1:0] STEP_XP     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_YM     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_YP     = 3'd4;
  localparam logic [STEP_W-1:0] STEP_ZM     = 3'd5;
  localparam logic [STEP_W-1:0] STEP_ZP     = 3'd6;

  localparam logic signed [FIELD_W-1:0]  TERM_POS    = 4'sd1;
  localparam logic signed [FIELD_W-1:0]  TERM_NEG    = -4'sd1;
  localparam logic signed [ENERGY_W-1:0] ENERGY_ZERO = 5'sd0;
  localparam logic signed [ENERGY_W-1:0] DE_FOUR     = 5'sd4;
  localparam logic signed [ENERGY_W-1:0] DE_EIGHT    = 5'sd8;
  localparam logic signed [ENERGY_W-1:0] DE_TWELVE   = 5'sd12;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic coupling;
    logic spin_b;
    logic spin_a;
  } site_word_t;

  typedef struct packed {
    logic                        accepted;
    logic signed [ENERGY_W-1:0]  energy;
    logic                        spin_new;
  } verdict_t;

endpackage
`default_nettype wire

// File: sv/slm_ram.sv
// Generic single write port, single read port RAM with a registered read.
`default_nettype none
module slm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/slm_addr.sv
// Site address generator for the center site and its six wrapped neighbors.
`default_nettype none
module slm_addr #(
  parameter int SIDE = slm_pkg::SIDE_DEFAULT,
  localparam int CW = ($clog2(SIDE) < 2) ? 2 : $clog2(SIDE),
  localparam int AW = $clog2(SIDE * SIDE * SIDE)
) (
  input  logic [CW-1:0]               x,
  input  logic [CW-1:0]               y,
  input  logic [CW-1:0]               z,
  input  logic [slm_pkg::STEP_W-1:0]  step,
  output logic [AW-1:0]               addr
);
  import slm_pkg::*;

  localparam logic [CW-1:0] SIDE_M1 = CW'(SIDE - 1);
  localparam logic [AW-1:0] SIDE_A  = AW'(SIDE);

  logic [CW-1:0] nx;
  logic [CW-1:0] ny;
  logic [CW-1:0] nz;

  function automatic logic [CW-1:0] dec_wrap(input logic [CW-1:0] c);
    return (c == '0) ? SIDE_M1 : CW'(c - 1'b1);
  endfunction

  function automatic logic [CW-1:0] inc_wrap(input logic [CW-1:0] c);
    return (c == SIDE_M1) ? '0 : CW'(c + 1'b1);
  endfunction

  always_comb begin
    nx = x;
    ny = y;
    nz = z;
    unique case (step)
      STEP_XM: nx = dec_wrap(x);
      STEP_XP: nx = inc_wrap(x);
      STEP_YM: ny = dec_wrap(y);
      STEP_YP: ny = inc_wrap(y);
      STEP_ZM: nz = dec_wrap(z);
      STEP_ZP: nz = inc_wrap(z);
      default: begin
      end
    endcase
  end

  assign addr = AW'((AW'(nx) * SIDE_A + AW'(ny)) * SIDE_A + AW'(nz));

endmodule
`default_nettype wire

// File: sv/slm_decide.sv
// Energy change and Metropolis acceptance decision for one site.
`default_nettype none
module slm_decide (
  input  logic [slm_pkg::FUNC_W-1:0]         func,
  input  logic                               spin,
  input  logic signed [slm_pkg::FIELD_W-1:0] field,
  input  logic                               propose,
  input  logic [slm_pkg::THR_W-1:0]          rnd,
  input  logic [slm_pkg::THR_W-1:0]          thr_four,
  input  logic [slm_pkg::THR_W-1:0]          thr_eight,
  input  logic [slm_pkg::THR_W-1:0]          thr_twelve,
  output slm_pkg::verdict_t                  verdict
);
  import slm_pkg::*;

  logic signed [ENERGY_W-1:0] twice;
  logic signed [ENERGY_W-1:0] de;
  logic                       accepted;

  assign twice = {field, 1'b0};

  always_comb begin
    de = ENERGY_ZERO;
    if ((func == FUNC_UPDATE) && propose) begin
      de = spin ? twice : -twice;
    end
  end

  always_comb begin
    accepted = 1'b0;
    if ((func == FUNC_UPDATE) && propose) begin
      priority if (de <= ENERGY_ZERO) begin
        accepted = 1'b1;
      end else if (de == DE_FOUR) begin
        accepted = (rnd <= thr_four);
      end else if (de == DE_EIGHT) begin
        accepted = (rnd <= thr_eight);
      end else if (de == DE_TWELVE) begin
        accepted = (rnd <= thr_twelve);
      end else begin
        accepted = 1'b0;
      end
    end
  end

  assign verdict.accepted = accepted;
  assign verdict.energy   = de;
  assign verdict.spin_new = spin ^ accepted;

endmodule
`default_nettype wire

// File: sv/spin_lattice_metropolis_update.sv
// Top level: two replica spin lattices and a coupling table with a Metropolis update engine.
//
//   Channel  Dir  Handshake                Contents
//   in       in   in_valid / in_ready      func, replica, pos_x/y/z, write_bit,
//                                          flip_proposed, accept_random
//   out      out  out_valid / out_ready    spin_after, flip_accepted, energy_change,
//                                          local_field
//   cfg      in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A write request reads only the center site and an update request makes seven reads,
// through the single read port of the site memory, before decision and write back; a new
// request is taken only in the idle state after write back, not while one is in flight.
// After reset a clearing pass writes every site before the first request is accepted.
// A stalled result stalls only the write back of the following request; the next request
// is accepted while a result waits.
`default_nettype none
module spin_lattice_metropolis_update #(
  parameter int SIDE = slm_pkg::SIDE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [slm_pkg::FUNC_W-1:0]          func,
  input  logic                                replica,
  input  logic [slm_pkg::COORD_W-1:0]         pos_x,
  input  logic [slm_pkg::COORD_W-1:0]         pos_y,
  input  logic [slm_pkg::COORD_W-1:0]         pos_z,
  input  logic                                write_bit,
  input  logic                                flip_proposed,
  input  logic [slm_pkg::THR_W-1:0]           accept_random,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                spin_after,
  output logic                                flip_accepted,
  output logic signed [slm_pkg::ENERGY_W-1:0] energy_change,
  output logic signed [slm_pkg::FIELD_W-1:0]  local_field,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [slm_pkg::THR_W-1:0]           cfg_data
);
  import slm_pkg::*;

  localparam int SITES = SIDE * SIDE * SIDE;
  localparam int CW    = ($clog2(SIDE) < 2) ? 2 : $clog2(SIDE);
  localparam int AW    = $clog2(SITES);
  localparam int WW    = $bits(site_word_t);

  localparam logic [CW:0]   SIDE_W    = (CW + 1)'(SIDE);
  localparam logic [AW-1:0] LAST_SITE = AW'(SITES - 1);

  state_t state;
  state_t state_next;

  logic [STEP_W-1:0]   cnt;
  logic                pend;
  logic [STEP_W-1:0]   pend_step;
  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       center_addr;
  site_word_t          center;
  logic signed [FIELD_W-1:0] field;

  logic [FUNC_W-1:0]   func_q;
  logic                replica_q;
  logic [CW-1:0]       x_q;
  logic [CW-1:0]       y_q;
  logic [CW-1:0]       z_q;
  logic                wbit_q;
  logic                propose_q;
  logic [THR_W-1:0]    rnd_q;

  logic [THR_W-1:0]    thr_four;
  logic [THR_W-1:0]    thr_eight;
  logic [THR_W-1:0]    thr_twelve;

  logic                accept_in;
  logic                commit;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  site_word_t          mem_wdata;
  logic [AW-1:0]       rd_addr;
  logic [WW-1:0]       rd_data;
  site_word_t          rd_word;
  logic                rd_spin;
  logic                center_spin;
  site_word_t          new_word;
  verdict_t            verdict;

  function automatic logic [CW-1:0] reduce(input logic [COORD_W-1:0] p);
    logic [CW-1:0] ext;
    ext = CW'(p);
    return ({1'b0, ext} >= SIDE_W) ? CW'(ext - SIDE_W[CW-1:0]) : ext;
  endfunction

  slm_ram #(
    .WIDTH(WW),
    .DEPTH(SITES)
  ) u_sites (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  slm_addr #(
    .SIDE(SIDE)
  ) u_addr (
    .x   (x_q),
    .y   (y_q),
    .z   (z_q),
    .step(cnt),
    .addr(rd_addr)
  );

  assign rd_word     = site_word_t'(rd_data);
  assign rd_spin     = replica_q ? rd_word.spin_b : rd_word.spin_a;
  assign center_spin = replica_q ? center.spin_b : center.spin_a;

  slm_decide u_decide (
    .func      (func_q),
    .spin      (center_spin),
    .field     (field),
    .propose   (propose_q),
    .rnd       (rnd_q),
    .thr_four  (thr_four),
    .thr_eight (thr_eight),
    .thr_twelve(thr_twelve),
    .verdict   (verdict)
  );

  always_comb begin
    new_word = center;
    unique case (func_q)
      FUNC_WRITE_SPIN: begin
        if (replica_q) begin
          new_word.spin_b = wbit_q;
        end else begin
          new_word.spin_a = wbit_q;
        end
      end
      FUNC_WRITE_COUPLING: new_word.coupling = wbit_q;
      FUNC_UPDATE: begin
        if (replica_q) begin
          new_word.spin_b = verdict.spin_new;
        end else begin
          new_word.spin_a = verdict.spin_new;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_SITE) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (((cnt == STEP_CENTER) && (func_q != FUNC_UPDATE)) || (cnt == STEP_ZP)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    commit    = (state == ST_FINISH) && (!out_valid || out_ready);
    mem_we    = 1'b0;
    mem_waddr = center_addr;
    mem_wdata = new_word;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '1;
      end
      ST_FINISH: mem_we = commit;
      default: begin
      end
    endcase
  end

  assign accept_in = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
      thr_four   <= THR_FOUR_RESET;
      thr_eight  <= THR_EIGHT_RESET;
      thr_twelve <= THR_TWELVE_RESET;
    end else begin
      state <= state_next;
      pend  <= (state == ST_READ);
      if (state == ST_CLEAR) begin
        clr_addr <= AW'(clr_addr + 1'b1);
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ACCEPT_AT_FOUR:   thr_four   <= cfg_data;
          CFG_ACCEPT_AT_EIGHT:  thr_eight  <= cfg_data;
          CFG_ACCEPT_AT_TWELVE: thr_twelve <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_step <= cnt;
    if (accept_in) begin
      func_q    <= func;
      replica_q <= replica;
      x_q       <= reduce(pos_x);
      y_q       <= reduce(pos_y);
      z_q       <= reduce(pos_z);
      wbit_q    <= write_bit;
      propose_q <= flip_proposed;
      rnd_q     <= accept_random;
      cnt       <= STEP_CENTER;
      field     <= '0;
    end else if (state == ST_READ) begin
      cnt <= STEP_W'(cnt + 1'b1);
    end
    if ((state == ST_READ) && (cnt == STEP_CENTER)) begin
      center_addr <= rd_addr;
    end
    if (pend) begin
      if (pend_step == STEP_CENTER) begin
        center <= rd_word;
      end else begin
        field <= field + ((rd_word.coupling == rd_spin) ? TERM_POS : TERM_NEG);
      end
    end
    if (commit) begin
      spin_after    <= replica_q ? new_word.spin_b : new_word.spin_a;
      flip_accepted <= verdict.accepted;
      energy_change <= verdict.energy;
      local_field   <= field;
    end
  end

endmodule
`default_nettype wire

// File: sv/slm_check.sv
// Port-level checker for the spin lattice Metropolis update block, with its bind.
`default_nettype none
module slm_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                spin_after,
  input logic                                flip_accepted,
  input logic signed [slm_pkg::ENERGY_W-1:0] energy_change,
  input logic signed [slm_pkg::FIELD_W-1:0]  local_field
);
  import slm_pkg::*;

  // A held result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(spin_after) &&
      $stable(flip_accepted) && $stable(energy_change) && $stable(local_field))
    else $error("result changed while stalled");

  // One request is worked on at a time, so acceptance closes the input side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while busy");

  // A negative energy change is always accepted.
  a_downhill: assert property (@(posedge clk) disable iff (rst)
    out_valid && (energy_change < ENERGY_ZERO) |-> flip_accepted)
    else $error("downhill move rejected");

  // A nonzero energy change is twice the local field in magnitude.
  a_energy_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && (energy_change != ENERGY_ZERO) |->
      (energy_change == {local_field, 1'b0}) || (energy_change == -{local_field, 1'b0}))
    else $error("energy change does not match local field");

endmodule

bind spin_lattice_metropolis_update slm_check u_slm_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .spin_after   (spin_after),
  .flip_accepted(flip_accepted),
  .energy_change(energy_change),
  .local_field  (local_field)
);
`default_nettype wire
